// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the scanline unfilter block.
// Synthesis builds define SYNTHESIS and get empty macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed");

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond)

`endif

`endif

// ===== rtl/pngsu_pkg.sv =====
// Package for the PNG scanline unfilter block: sizes, filter and register
// codes, the stage control type and the Paeth predictor. No dependencies.
`timescale 1ns / 1ps

package pngsu_pkg;

  localparam int MAX_ROW_BYTES   = 4096;
  localparam int ROW_AW          = $clog2(MAX_ROW_BYTES);
  localparam int POS_W           = ROW_AW + 1;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int SEL_W           = $clog2(MAX_PIXEL_BYTES);
  localparam int ROW_BYTES_W     = 13;
  localparam int BPP_W           = 4;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [7:0] FILT_LAST_CODE = 8'd4;

  // Register index is paddr[2]: registers lie at byte addresses 0 and 4.
  localparam logic REG_ROW_BYTES = 1'b0;
  localparam logic REG_BPP       = 1'b1;

  // Control carried from the accept stage to the reconstruct stage.
  typedef struct packed {
    logic [7:0]        raw;
    logic [2:0]        filter;
    logic              first_row;
    logic              has_left;
    logic [SEL_W-1:0]  sel;
    logic [ROW_AW-1:0] index;
    logic              last;
    logic              bad;
  } s1_ctrl_t;

  // Paeth predictor with p = a + b - c expressed through distances.
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [8:0] da;
    logic [8:0] db;
    logic [9:0] sum;
    logic [9:0] twoc;
    logic [9:0] dc;
    da   = (b >= c) ? ({1'b0, b} - {1'b0, c}) : ({1'b0, c} - {1'b0, b});
    db   = (a >= c) ? ({1'b0, a} - {1'b0, c}) : ({1'b0, c} - {1'b0, a});
    sum  = {2'b00, a} + {2'b00, b};
    twoc = {1'b0, c, 1'b0};
    dc   = (sum >= twoc) ? (sum - twoc) : (twoc - sum);
    if (({1'b0, da} <= {1'b0, db}) && ({1'b0, da} <= dc)) begin
      paeth = a;
    end else if ({1'b0, db} <= dc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

endpackage

// ===== rtl/png_scanline_unfilter_unit.sv =====
// Top level of the PNG scanline unfilter: line store, neighbor histories,
// two-stage reconstruct pipeline and APB register block. Uses pngsu_pkg
// and assert_macros.svh.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   s_axis_tvalid/tready    tdata=data_byte, tuser=frame_start
//  m_axis    out  m_axis_tvalid/tready    tdata=pixel_byte, tlast=row_end,
//                                         tuser=bad_filter
//  apb       in   psel/penable/pready     paddr, pwdata, prdata
//
// One byte is accepted per cycle while s_axis_tready is high. A data byte
// and its line store read are captured in the stage register at its
// transfer, and it moves into the output register when that register is free.
// Reset is synchronous; the line store itself is never cleared, since each
// row only reads entries the previous row wrote.
// A stalled m_axis holds the output register and a full stage register; s_axis_tready drops only when both are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module png_scanline_unfilter_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
  input  logic                             s_axis_tuser,  // [0] frame_start
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [7:0] pixel_byte
  output logic                             m_axis_tlast,
  output logic                             m_axis_tuser,  // [0] bad_filter
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pngsu_pkg::CFG_AW-1:0]     paddr,
  input  logic [pngsu_pkg::CFG_DW-1:0]     pwdata,
  output logic [pngsu_pkg::CFG_DW-1:0]     prdata,
  output logic                             pready
);

  // Configuration registers.
  logic [pngsu_pkg::ROW_BYTES_W-1:0] row_bytes;
  logic [pngsu_pkg::BPP_W-1:0]       pixel_bytes;

  // Accept-stage state.
  logic [pngsu_pkg::POS_W-1:0] byte_position;
  logic [2:0]                  current_filter;
  logic                        on_first_row;
  logic                        discarding;

  // Neighbor histories, newest byte at index 0.
  logic [7:0] left_hist [pngsu_pkg::MAX_PIXEL_BYTES];
  logic [7:0] ul_hist   [pngsu_pkg::MAX_PIXEL_BYTES];

  // Line store holding the previous row.
  logic [7:0] line_mem [pngsu_pkg::MAX_ROW_BYTES];
  logic [7:0] above_rdata;

  logic                 s1_valid;
  pngsu_pkg::s1_ctrl_t  s1;

  logic                            in_acc;
  logic                            s1_adv;
  logic                            fs;
  logic [pngsu_pkg::POS_W-1:0]     rb_eff;
  logic [pngsu_pkg::BPP_W-1:0]     bpp_eff;
  logic [pngsu_pkg::BPP_W-1:0]     bpp_m1;
  logic [pngsu_pkg::POS_W-1:0]     pos_eff;
  logic [pngsu_pkg::POS_W-1:0]     pos_m1;
  logic                            disc_eff;
  logic                            first_eff;
  logic                            is_filter;
  logic                            is_bad;
  logic                            is_data;
  logic                            last;
  logic                            has_left;
  logic                            mem_re;
  logic                            mem_we;
  logic [7:0]                      a_val;
  logic [7:0]                      b_val;
  logic [7:0]                      c_val;
  logic [8:0]                      avg_sum;
  logic [7:0]                      pred;
  logic [7:0]                      pix;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= pngsu_pkg::ROW_BYTES_W'(1);
      pixel_bytes <= pngsu_pkg::BPP_W'(1);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        pngsu_pkg::REG_ROW_BYTES: row_bytes   <= pwdata[pngsu_pkg::ROW_BYTES_W-1:0];
        pngsu_pkg::REG_BPP:       pixel_bytes <= pwdata[pngsu_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pngsu_pkg::REG_ROW_BYTES: prdata = pngsu_pkg::CFG_DW'(row_bytes);
      pngsu_pkg::REG_BPP:       prdata = pngsu_pkg::CFG_DW'(pixel_bytes);
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------- accept stage
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign fs            = s_axis_tuser;

  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = pngsu_pkg::POS_W'(1);
    end else if (pngsu_pkg::POS_W'(row_bytes) > pngsu_pkg::POS_W'(pngsu_pkg::MAX_ROW_BYTES))
    begin
      rb_eff = pngsu_pkg::POS_W'(pngsu_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = pngsu_pkg::POS_W'(row_bytes);
    end
    if (pixel_bytes == '0) begin
      bpp_eff = pngsu_pkg::BPP_W'(1);
    end else if (pixel_bytes > pngsu_pkg::BPP_W'(pngsu_pkg::MAX_PIXEL_BYTES)) begin
      bpp_eff = pngsu_pkg::BPP_W'(pngsu_pkg::MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = pixel_bytes;
    end
  end

  // A frame start restarts the row and history before the byte is judged.
  assign pos_eff   = fs ? '0 : byte_position;
  assign disc_eff  = discarding && !fs;
  assign first_eff = on_first_row || fs;
  assign is_filter = !disc_eff && (pos_eff == '0);
  assign is_bad    = is_filter && (s_axis_tdata > pngsu_pkg::FILT_LAST_CODE);
  assign is_data   = !disc_eff && (pos_eff != '0);
  assign pos_m1    = pos_eff - pngsu_pkg::POS_W'(1);
  assign bpp_m1    = bpp_eff - pngsu_pkg::BPP_W'(1);
  assign has_left  = pos_m1 >= pngsu_pkg::POS_W'(bpp_eff);
  assign last      = pos_eff >= rb_eff;
  assign mem_re    = in_acc && is_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      current_filter <= pngsu_pkg::FILT_NONE;
      on_first_row   <= 1'b1;
      discarding     <= 1'b0;
    end else if (in_acc) begin
      discarding <= is_bad || disc_eff;
      if (is_filter && !is_bad) begin
        byte_position  <= pngsu_pkg::POS_W'(1);
        current_filter <= s_axis_tdata[2:0];
        on_first_row   <= first_eff;
      end else if (is_data) begin
        byte_position <= last ? '0 : (pos_eff + pngsu_pkg::POS_W'(1));
        on_first_row  <= first_eff && !last;
      end else begin
        byte_position <= pos_eff;
        on_first_row  <= first_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= is_data || is_bad;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1.raw       <= s_axis_tdata;
      s1.filter    <= current_filter;
      s1.first_row <= first_eff;
      s1.has_left  <= has_left;
      s1.sel       <= bpp_m1[pngsu_pkg::SEL_W-1:0];
      s1.index     <= pos_m1[pngsu_pkg::ROW_AW-1:0];
      s1.last      <= last;
      s1.bad       <= is_bad;
    end
  end

  // ---------------------------------------------------------- line store
  // Consecutive data bytes touch neighboring entries, and a row always has
  // a filter byte between its last write and the next row's read of the
  // same entry, so the write always lands before that read.
  assign mem_we = s1_adv && !s1.bad;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1.index] <= pix;
    end
    if (mem_re) begin
      above_rdata <= line_mem[pos_m1[pngsu_pkg::ROW_AW-1:0]];
    end
  end

  // ---------------------------------------------------- reconstruct stage
  always_comb begin
    a_val   = s1.has_left ? left_hist[s1.sel] : 8'd0;
    b_val   = s1.first_row ? 8'd0 : above_rdata;
    c_val   = (s1.has_left && !s1.first_row) ? ul_hist[s1.sel] : 8'd0;
    avg_sum = {1'b0, a_val} + {1'b0, b_val};
    case (s1.filter)
      pngsu_pkg::FILT_SUB:   pred = a_val;
      pngsu_pkg::FILT_UP:    pred = b_val;
      pngsu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      pngsu_pkg::FILT_PAETH: pred = pngsu_pkg::paeth(a_val, b_val, c_val);
      default:               pred = 8'd0;
    endcase
    pix = s1.raw + pred;
  end

  // A frame start clears the histories after any shift in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pngsu_pkg::MAX_PIXEL_BYTES; k++) begin
        left_hist[k] <= 8'd0;
        ul_hist[k]   <= 8'd0;
      end
    end else if (in_acc && fs) begin
      for (int k = 0; k < pngsu_pkg::MAX_PIXEL_BYTES; k++) begin
        left_hist[k] <= 8'd0;
        ul_hist[k]   <= 8'd0;
      end
    end else if (mem_we) begin
      for (int k = pngsu_pkg::MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_hist[k] <= left_hist[k-1];
        ul_hist[k]   <= ul_hist[k-1];
      end
      left_hist[0] <= pix;
      ul_hist[0]   <= b_val;
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_axis_tdata <= s1.bad ? 8'd0 : pix;
      m_axis_tlast <= !s1.bad && s1.last;
      m_axis_tuser <= s1.bad;
    end
  end

  // ----------------------------------------------------------- assertions
  `ASSERT_ALWAYS(a_pos_in_range, clk, rst, byte_position <= pngsu_pkg::POS_W'(pngsu_pkg::MAX_ROW_BYTES))
  `ASSERT_NEVER(a_no_same_entry, clk, rst, mem_we && mem_re && (s1.index == pos_m1[pngsu_pkg::ROW_AW-1:0]))
  `ASSERT_ALWAYS(a_drop_no_work, clk, rst, (discarding && in_acc && !fs) |=> !s1_valid)
  `ASSERT_ALWAYS(a_bad_result_clean, clk, rst, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0 && !m_axis_tlast))

endmodule
